// File: rtl/hfe_pkg.sv
package hfe_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE = 8'h7D;
   localparam logic [7:0] ESC_XOR = 8'h20;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   localparam logic [2:0] PH_OPEN = 3'd0;
   localparam logic [2:0] PH_DATA = 3'd1;
   localparam logic [2:0] PH_FCS_LO = 3'd2;
   localparam logic [2:0] PH_FCS_HI = 3'd3;
   localparam logic [2:0] PH_CLOSE = 3'd4;

   typedef struct packed {
      logic        open_flag;
      logic [7:0]  data;
      logic        last;
      logic [15:0] fcs;
   } cmd_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/hfe_front.sv
module hfe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   input  logic                 queue_full,
   output logic                 req_ready,
   output logic                 push,
   output hfe_pkg::cmd_type     push_cmd
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic        in_frame_ff;
   logic        in_frame_in;
   logic [15:0] crc_next;

   assign req_ready = !queue_full;
   assign push = req_valid && !queue_full;
   assign crc_next = hfe_pkg::crc_update(crc_ff, req_data_byte);

   always_comb begin
      push_cmd.open_flag = !in_frame_ff;
      push_cmd.data = req_data_byte;
      push_cmd.last = req_last_byte;
      push_cmd.fcs = ~crc_next;
      crc_in = crc_ff;
      in_frame_in = in_frame_ff;
      if (push) begin
         if (req_last_byte) begin
            crc_in = hfe_pkg::CRC_INIT;
            in_frame_in = 1'b0;
         end else begin
            crc_in = crc_next;
            in_frame_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= hfe_pkg::CRC_INIT;
         in_frame_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// File: rtl/hfe_queue.sv
module hfe_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hfe_pkg::cmd_type     push_cmd,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output hfe_pkg::cmd_type     head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   hfe_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/hfe_back.sv
module hfe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  hfe_pkg::cmd_type     head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_frame_end
);

   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic       esc_ff;
   logic       esc_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       run_last_ff;
   logic       frame_end_ff;
   logic       load;
   logic [2:0] eff_phase;
   logic [7:0] cur_byte;
   logic [7:0] emit_byte;
   logic       emit_last;
   logic       emit_end;
   logic       byte_done;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign eff_phase = (phase_ff == hfe_pkg::PH_OPEN && !head_cmd.open_flag) ?
                      hfe_pkg::PH_DATA : phase_ff;

   always_comb begin
      case (eff_phase)
         hfe_pkg::PH_FCS_LO: cur_byte = head_cmd.fcs[7:0];
         hfe_pkg::PH_FCS_HI: cur_byte = head_cmd.fcs[15:8];
         default:            cur_byte = head_cmd.data;
      endcase
   end

   always_comb begin
      emit_byte = cur_byte;
      emit_last = 1'b0;
      emit_end = 1'b0;
      byte_done = 1'b0;
      pop = 1'b0;
      phase_in = phase_ff;
      esc_in = esc_ff;
      case (eff_phase)
         hfe_pkg::PH_OPEN: begin
            emit_byte = hfe_pkg::FLAG_BYTE;
            phase_in = hfe_pkg::PH_DATA;
         end
         hfe_pkg::PH_CLOSE: begin
            emit_byte = hfe_pkg::FLAG_BYTE;
            emit_last = 1'b1;
            emit_end = 1'b1;
            pop = 1'b1;
            phase_in = hfe_pkg::PH_OPEN;
         end
         hfe_pkg::PH_DATA, hfe_pkg::PH_FCS_LO, hfe_pkg::PH_FCS_HI: begin
            if (esc_ff) begin
               emit_byte = cur_byte ^ hfe_pkg::ESC_XOR;
               esc_in = 1'b0;
               byte_done = 1'b1;
            end else if (cur_byte == hfe_pkg::FLAG_BYTE || cur_byte == hfe_pkg::ESC_BYTE) begin
               emit_byte = hfe_pkg::ESC_BYTE;
               esc_in = 1'b1;
               phase_in = eff_phase;
            end else begin
               byte_done = 1'b1;
            end
            if (byte_done) begin
               if (eff_phase == hfe_pkg::PH_DATA) begin
                  if (head_cmd.last) begin
                     phase_in = hfe_pkg::PH_FCS_LO;
                  end else begin
                     emit_last = 1'b1;
                     pop = 1'b1;
                     phase_in = hfe_pkg::PH_OPEN;
                  end
               end else if (eff_phase == hfe_pkg::PH_FCS_LO) begin
                  phase_in = hfe_pkg::PH_FCS_HI;
               end else begin
                  phase_in = hfe_pkg::PH_CLOSE;
               end
            end
         end
         default: begin
            phase_in = hfe_pkg::PH_OPEN;
            esc_in = 1'b0;
         end
      endcase
      if (!load) begin
         pop = 1'b0;
         phase_in = phase_ff;
         esc_in = esc_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hfe_pkg::PH_OPEN;
         esc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= emit_byte;
         run_last_ff <= emit_last;
         frame_end_ff <= emit_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// File: rtl/hdlc_frame_encoder_crc16.sv
// Asynchronous HDLC framer with a CRC-16/X.25 frame check sequence.
// The request channel takes one payload byte per transfer together with a
// mark that says whether it ends the frame. The response channel gives one
// line byte per transfer: the opening flag before a frame's first byte, each
// payload byte stuffed into one or two bytes, and on the last byte the
// complemented CRC (low byte first, stuffed) and the closing flag.
// The front computes the CRC of a byte in the cycle it is accepted and places
// a command in a small queue of QUEUE_DEPTH entries; the back sequences the
// line bytes of each command into the output register.
// The first line byte of an item passes through the queue and then the output register.
// The back emits one line byte per cycle while the receiver is ready; an item
// causes 1 to 8 line bytes, one or two per payload byte plus flags and CRC.
// Reset clears the CRC to 0xFFFF, drops any open frame, and empties the
// queue and the output register. When the receiver stalls, the output holds
// and the queue absorbs further requests until it fills; then req_ready drops.
module hdlc_frame_encoder_crc16 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   hfe_pkg::cmd_type push_cmd;
   hfe_pkg::cmd_type head_cmd;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             head_valid;

   hfe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .req_ready     (req_ready),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   hfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   hfe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
